>>> rtl/core/hfmm_pkg.sv
// ----------------------------------------------------------------------------
// hfmm_pkg
// Shared types and codes of the fp16-input, fp32-accumulate matrix multiplier.
// ----------------------------------------------------------------------------
package hfmm_pkg;

  localparam int IDX_W       = 6;
  localparam int VAL_W       = 16;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int INDEX_LIMIT = 64;

  localparam logic [1:0] ACT_LOAD_A  = 2'd0;
  localparam logic [1:0] ACT_LOAD_B  = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DEPTH = 2'd2;

  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic [VAL_W-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
    logic [VAL_W-1:0] out_value;
    logic             out_last;
  } out_item_t;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_en;
    logic             mul_en;
    logic             norm_en;
    logic             add1_en;
    logic             add2_en;
    logic             acc_clear;
    logic             out_load;
    logic             out_last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] term;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/core/hfmm_stream_if.sv
// ----------------------------------------------------------------------------
// hfmm_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface hfmm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/hfmm_ctrl.sv
// ----------------------------------------------------------------------------
// hfmm_ctrl
// Sequencer: size registers, item decode and the column/term loop control.
// ----------------------------------------------------------------------------
module hfmm_ctrl #(
  parameter int DIM_MAX = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hfmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfmm_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hfmm_pkg::in_item_t             in_item,
  input  hfmm_pkg::dp_status_t           status,
  output hfmm_pkg::dp_cmd_t              cmd
);

  localparam int LIM = (DIM_MAX < hfmm_pkg::INDEX_LIMIT) ? DIM_MAX : hfmm_pkg::INDEX_LIMIT;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_READ = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_NORM = 7'b0001000,
    ST_ADD1 = 7'b0010000,
    ST_ADD2 = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  function automatic logic [hfmm_pkg::CFG_W-1:0] eff(input logic [hfmm_pkg::CFG_W-1:0] v);
    eff = (int'(v) < LIM) ? v : hfmm_pkg::CFG_W'(LIM);
  endfunction

  state_t                          state_r, state_nxt;
  logic [hfmm_pkg::CFG_W-1:0]      row_count_r, col_count_r, inner_depth_r;
  logic [hfmm_pkg::IDX_W-1:0]      r_r, r_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [hfmm_pkg::CFG_W-1:0]      rows_eff, cols_eff, depth_eff;
  logic                            in_range, col_last, term_last;

  assign rows_eff  = eff(row_count_r);
  assign cols_eff  = eff(col_count_r);
  assign depth_eff = eff(inner_depth_r);
  assign in_range  = (int'(in_item.row_index) < DIM_MAX) && (int'(in_item.col_index) < DIM_MAX);
  assign col_last  = (({1'b0, j_r} + 7'd1) == cols_eff);
  assign term_last = (({1'b0, k_r} + 7'd1) == depth_eff);
  assign in_ready  = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r   <= hfmm_pkg::SIZE_RESET;
      col_count_r   <= hfmm_pkg::SIZE_RESET;
      inner_depth_r <= hfmm_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hfmm_pkg::CFG_ROW_COUNT:   row_count_r   <= cfg_wdata;
        hfmm_pkg::CFG_COL_COUNT:   col_count_r   <= cfg_wdata;
        hfmm_pkg::CFG_INNER_DEPTH: inner_depth_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      r_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cmd       = '0;
    cmd.row   = r_r;
    cmd.col   = j_r;
    cmd.term  = k_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.row = in_item.row_index;
        cmd.col = in_item.col_index;
        if (in_valid) begin
          unique case (in_item.action)
            hfmm_pkg::ACT_LOAD_A: cmd.wr_a = in_range;
            hfmm_pkg::ACT_LOAD_B: cmd.wr_b = in_range;
            hfmm_pkg::ACT_COMPUTE: begin
              if (({1'b0, in_item.row_index} < rows_eff) && (cols_eff != '0)) begin
                r_nxt         = in_item.row_index;
                j_nxt         = '0;
                k_nxt         = '0;
                cmd.acc_clear = 1'b1;
                state_nxt     = (depth_eff == '0) ? ST_EMIT : ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_NORM;
      end
      ST_NORM: begin
        cmd.norm_en = 1'b1;
        state_nxt   = ST_ADD1;
      end
      ST_ADD1: begin
        cmd.add1_en = 1'b1;
        state_nxt   = ST_ADD2;
      end
      ST_ADD2: begin
        cmd.add2_en = 1'b1;
        if (term_last) begin
          state_nxt = ST_EMIT;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_last  = col_last;
          cmd.acc_clear = 1'b1;
          if (col_last) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + 1'b1;
            k_nxt     = '0;
            state_nxt = (depth_eff == '0) ? ST_EMIT : ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/hfmm_dp.sv
// ----------------------------------------------------------------------------
// hfmm_dp
// Datapath: element stores, fp16 multiplier, fp32 adder, accumulator and the
// result register with fp16 rounding.
// ----------------------------------------------------------------------------
module hfmm_dp #(
  parameter int DIM_MAX = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hfmm_pkg::dp_cmd_t          cmd,
  input  logic [hfmm_pkg::VAL_W-1:0] elem_value,
  input  logic                       out_ready,
  output logic                       out_valid,
  output hfmm_pkg::out_item_t        out_item,
  output hfmm_pkg::dp_status_t       status
);

  localparam int MEM_DEPTH = DIM_MAX * DIM_MAX;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam logic [31:0] QNAN32 = 32'h7FC0_0000;

  function automatic logic [4:0] lz22(input logic [21:0] v);
    lz22 = 5'd0;
    for (int i = 0; i < 22; i++) begin
      if (v[i]) lz22 = 5'(21 - i);
    end
  endfunction

  function automatic logic [4:0] lz27(input logic [26:0] v);
    lz27 = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) lz27 = 5'(26 - i);
    end
  endfunction

  function automatic logic [15:0] f32_to_f16(input logic [31:0] b);
    logic        s;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [14:0] h;
    logic [12:0] rem;
    logic [23:0] full, hs, rmask, halfv;
    logic [4:0]  sh;
    s     = b[31];
    ex    = b[30:23];
    man   = b[22:0];
    h     = '0;
    rem   = '0;
    full  = {1'b1, man};
    sh    = '0;
    hs    = '0;
    rmask = '0;
    halfv = '0;
    if (ex == 8'hFF) begin
      f32_to_f16 = (man != '0) ? 16'h7E00 : {s, 15'h7C00};
    end else if (ex >= 8'd143) begin
      f32_to_f16 = {s, 15'h7C00};
    end else if (ex >= 8'd113) begin
      h   = {5'(ex - 8'd112), man[22:13]};
      rem = man[12:0];
      if ((rem > 13'h1000) || ((rem == 13'h1000) && h[0])) h = h + 15'd1;
      f32_to_f16 = {s, h};
    end else if (ex >= 8'd102) begin
      sh    = 5'(8'd126 - ex);
      hs    = full >> sh;
      rmask = (24'd1 << sh) - 24'd1;
      halfv = 24'd1 << (sh - 5'd1);
      h     = 15'(hs);
      if (((full & rmask) > halfv) || (((full & rmask) == halfv) && hs[0])) h = h + 15'd1;
      f32_to_f16 = {s, h};
    end else begin
      f32_to_f16 = {s, 15'h0000};
    end
  endfunction

  logic [hfmm_pkg::VAL_W-1:0] a_mem [MEM_DEPTH];
  logic [hfmm_pkg::VAL_W-1:0] b_mem [MEM_DEPTH];
  logic [hfmm_pkg::VAL_W-1:0] a_q_r, b_q_r;
  logic [ADDR_W-1:0]          wr_addr, a_rd_addr, b_rd_addr;

  assign wr_addr   = ADDR_W'(cmd.row) * ADDR_W'(DIM_MAX) + ADDR_W'(cmd.col);
  assign a_rd_addr = ADDR_W'(cmd.row) * ADDR_W'(DIM_MAX) + ADDR_W'(cmd.term);
  assign b_rd_addr = ADDR_W'(cmd.term) * ADDR_W'(DIM_MAX) + ADDR_W'(cmd.col);

  always_ff @(posedge clk) begin
    if (cmd.wr_a) a_mem[wr_addr] <= elem_value;
    if (cmd.rd_en) a_q_r <= a_mem[a_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b) b_mem[wr_addr] <= elem_value;
    if (cmd.rd_en) b_q_r <= b_mem[b_rd_addr];
  end

  // Multiply stage: the fp16 product is exact in fp32.
  logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  logic [10:0] a_m, b_m;
  logic [4:0]  a_e, b_e;
  logic        p_nan_r, p_inf_r, p_zero_r, p_sign_r;
  logic [21:0] p_raw_r;
  logic [5:0]  p_esum_r;

  assign a_nan  = (a_q_r[14:10] == 5'h1F) && (a_q_r[9:0] != '0);
  assign a_inf  = (a_q_r[14:10] == 5'h1F) && (a_q_r[9:0] == '0);
  assign a_zero = (a_q_r[14:0] == '0);
  assign b_nan  = (b_q_r[14:10] == 5'h1F) && (b_q_r[9:0] != '0);
  assign b_inf  = (b_q_r[14:10] == 5'h1F) && (b_q_r[9:0] == '0);
  assign b_zero = (b_q_r[14:0] == '0);
  assign a_m    = {(a_q_r[14:10] != '0), a_q_r[9:0]};
  assign b_m    = {(b_q_r[14:10] != '0), b_q_r[9:0]};
  assign a_e    = (a_q_r[14:10] == '0) ? 5'd1 : a_q_r[14:10];
  assign b_e    = (b_q_r[14:10] == '0) ? 5'd1 : b_q_r[14:10];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_nan_r  <= a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
      p_inf_r  <= a_inf || b_inf;
      p_zero_r <= a_zero || b_zero;
      p_sign_r <= a_q_r[15] ^ b_q_r[15];
      p_raw_r  <= 22'(a_m) * 22'(b_m);
      p_esum_r <= 6'(a_e) + 6'(b_e);
    end
  end

  // Normalize stage: pack the product as fp32 bits.
  logic [4:0]  p_lz;
  logic [21:0] p_shifted;
  logic [7:0]  p_exp;
  logic [31:0] prod_r;

  assign p_lz      = lz22(p_raw_r);
  assign p_shifted = p_raw_r << p_lz;
  assign p_exp     = 8'(p_esum_r) + 8'd98 - 8'(p_lz);

  always_ff @(posedge clk) begin
    if (cmd.norm_en) begin
      priority if (p_nan_r) begin
        prod_r <= QNAN32;
      end else if (p_inf_r) begin
        prod_r <= {p_sign_r, 8'hFF, 23'd0};
      end else if (p_zero_r) begin
        prod_r <= {p_sign_r, 31'd0};
      end else begin
        prod_r <= {p_sign_r, p_exp, p_shifted[20:0], 2'b00};
      end
    end
  end

  // Add stage one: special operands, alignment and the significand add.
  logic [31:0] acc_r;
  logic [7:0]  ae, pe, big_e, sml_e, dexp;
  logic        ac_nan, ac_inf, ac_zero, pr_nan, pr_inf, pr_zero, a_big, do_sub, big_s;
  logic [23:0] big_m, sml_m;
  logic [26:0] sml_ext, sml_sh;
  logic [27:0] sum;
  logic        s1_special_r, s1_sign_r;
  logic [31:0] s1_bits_r;
  logic [7:0]  s1_exp_r;
  logic [27:0] s1_sum_r;

  assign ae      = acc_r[30:23];
  assign pe      = prod_r[30:23];
  assign ac_nan  = (ae == 8'hFF) && (acc_r[22:0] != '0);
  assign ac_inf  = (ae == 8'hFF) && (acc_r[22:0] == '0);
  assign ac_zero = (ae == '0);
  assign pr_nan  = (pe == 8'hFF) && (prod_r[22:0] != '0);
  assign pr_inf  = (pe == 8'hFF) && (prod_r[22:0] == '0);
  assign pr_zero = (pe == '0);
  assign a_big   = (acc_r[30:0] >= prod_r[30:0]);
  assign big_e   = a_big ? ae : pe;
  assign sml_e   = a_big ? pe : ae;
  assign big_m   = a_big ? {1'b1, acc_r[22:0]} : {1'b1, prod_r[22:0]};
  assign sml_m   = a_big ? {1'b1, prod_r[22:0]} : {1'b1, acc_r[22:0]};
  assign big_s   = a_big ? acc_r[31] : prod_r[31];
  assign do_sub  = acc_r[31] ^ prod_r[31];
  assign dexp    = big_e - sml_e;
  assign sml_ext = {sml_m, 3'b000};

  always_comb begin
    if (dexp >= 8'd27) begin
      sml_sh = 27'd1;
    end else begin
      sml_sh = (sml_ext >> dexp) | 27'(|(sml_ext & ~(27'h7FF_FFFF << dexp)));
    end
    if (do_sub) begin
      sum = {1'b0, big_m, 3'b000} - {1'b0, sml_sh};
    end else begin
      sum = {1'b0, big_m, 3'b000} + {1'b0, sml_sh};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add1_en) begin
      s1_sign_r <= big_s;
      s1_exp_r  <= big_e;
      s1_sum_r  <= sum;
      priority if (ac_nan || pr_nan || (ac_inf && pr_inf && do_sub)) begin
        s1_special_r <= 1'b1;
        s1_bits_r    <= QNAN32;
      end else if (ac_inf || pr_zero) begin
        s1_special_r <= 1'b1;
        s1_bits_r    <= acc_r;
      end else if (pr_inf || ac_zero) begin
        s1_special_r <= 1'b1;
        s1_bits_r    <= prod_r;
      end else if (sum == '0) begin
        s1_special_r <= 1'b1;
        s1_bits_r    <= '0;
      end else begin
        s1_special_r <= 1'b0;
        s1_bits_r    <= '0;
      end
    end
  end

  // Add stage two: normalize, round to nearest even, write the accumulator.
  logic [4:0]  s2_lz;
  logic [26:0] s2_norm;
  logic [8:0]  s2_exp;
  logic        s2_up;
  logic [24:0] s2_m;
  logic [8:0]  s2_exp_fin;
  logic [22:0] s2_frac;

  assign s2_lz = lz27(s1_sum_r[26:0]);

  always_comb begin
    if (s1_sum_r[27]) begin
      s2_norm = {s1_sum_r[27:2], (s1_sum_r[1] | s1_sum_r[0])};
      s2_exp  = {1'b0, s1_exp_r} + 9'd1;
    end else begin
      s2_norm = s1_sum_r[26:0] << s2_lz;
      s2_exp  = {1'b0, s1_exp_r} - 9'(s2_lz);
    end
    s2_up = s2_norm[2] && ((s2_norm[1:0] != '0) || s2_norm[3]);
    s2_m  = {1'b0, s2_norm[26:3]} + 25'(s2_up);
    if (s2_m[24]) begin
      s2_exp_fin = s2_exp + 9'd1;
      s2_frac    = s2_m[23:1];
    end else begin
      s2_exp_fin = s2_exp;
      s2_frac    = s2_m[22:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.acc_clear) begin
      acc_r <= '0;
    end else if (cmd.add2_en) begin
      acc_r <= s1_special_r ? s1_bits_r : {s1_sign_r, s2_exp_fin[7:0], s2_frac};
    end
  end

  // Result register.
  logic                out_valid_r;
  hfmm_pkg::out_item_t out_item_r;

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_item        = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_r.out_row   <= cmd.row;
      out_item_r.out_col   <= cmd.col;
      out_item_r.out_value <= f32_to_f16(acc_r);
      out_item_r.out_last  <= cmd.out_last;
    end
  end

endmodule

>>> rtl/core/half_in_float_acc_matrix_multiply.sv
// ----------------------------------------------------------------------------
// half_in_float_acc_matrix_multiply
// Matrix multiply C = A x B with fp16 elements and an fp32 dot accumulator.
//
// in_chan carries items: load an A element, load a B element, or compute one
// row of C. A load is written as it is accepted. A compute on a row below
// row_count emits col_count results (capped at DIM_MAX and 64) on out_chan in
// column order, out_last set on the final column. Each term of a dot product
// takes five steps on the shared multiply-add unit (store read, multiply,
// product normalize, align-add, round), each result an emit step. in_chan is
// not ready while a row is being computed; it is ready again the cycle after
// the last result enters the output register. A stalled out_chan holds the
// pending result and pauses the sequencer. Reset restores the size registers
// to 64 and clears the accumulator; the element stores hold nothing defined
// until loaded. Size registers are written through cfg_we, cfg_index and
// cfg_wdata, by the user only while the block is idle; it is not checked.
// ----------------------------------------------------------------------------
module half_in_float_acc_matrix_multiply #(
  parameter int DIM_MAX = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  hfmm_stream_if.sink                    in_chan,
  hfmm_stream_if.source                  out_chan,
  input  logic                           cfg_we,
  input  logic [hfmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfmm_pkg::CFG_W-1:0]     cfg_wdata
);

  hfmm_pkg::dp_cmd_t    cmd;
  hfmm_pkg::dp_status_t status;
  hfmm_pkg::in_item_t   in_item;
  hfmm_pkg::out_item_t  out_item;
  logic                 in_ready;
  logic                 out_valid;

  assign in_item          = in_chan.payload;
  assign in_chan.ready    = in_ready;
  assign out_chan.valid   = out_valid;
  assign out_chan.payload = out_item;

  hfmm_ctrl #(
    .DIM_MAX (DIM_MAX)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .status    (status),
    .cmd       (cmd)
  );

  hfmm_dp #(
    .DIM_MAX (DIM_MAX)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .elem_value (in_item.elem_value),
    .out_ready  (out_chan.ready),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .status     (status)
  );

`ifndef SYNTHESIS
  a_no_read_while_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && cmd.rd_en))
    else $error("Store read issued while the input channel is ready.");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_chan.valid || out_chan.ready))
    else $error("Result register loaded while a result awaits transfer.");

  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.out_last) |=> in_ready)
    else $error("Input channel not ready after the last result of a row.");
`endif

endmodule
